FILE: rtl/rcpc_pkg.sv
package rcpc_pkg;

  localparam int unsigned FRAC_W = 24;
  localparam int unsigned NUM_W  = 56;   // dot product accumulator width
  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  typedef struct packed {
    logic              done;
    logic              sat;
    logic              rest;
    logic [FRAC_W-1:0] quot;
  } div_res_t;

endpackage

FILE: rtl/rcpc_ram.sv
module rcpc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/rcpc_div.sv
// floor(n * 2^16 / d), one quotient bit per cycle, saturating at 2^24-1
module rcpc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rcpc_pkg::NUM_W-1:0]     num_i,
  input  logic [rcpc_pkg::NUM_W-1:0]     den_i,
  output rcpc_pkg::div_res_t             res_o
);

  localparam int unsigned RW = rcpc_pkg::NUM_W + 16;
  localparam int unsigned DW = rcpc_pkg::NUM_W + rcpc_pkg::FRAC_W - 1;
  localparam int unsigned SW = rcpc_pkg::NUM_W + 8;

  logic                        busy_q, done_q, sat_q;
  logic [4:0]                  cnt_q;
  logic [RW-1:0]               r_q;
  logic [DW-1:0]               dsh_q;
  logic [rcpc_pkg::FRAC_W-1:0] quot_q;
  logic [DW-1:0]               r_ext, diff;
  logic                        ge, sat_now;

  assign r_ext   = DW'(r_q);
  assign ge      = r_ext >= dsh_q;
  assign diff    = r_ext - dsh_q;
  assign sat_now = SW'(num_i) >= {den_i, 8'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (sat_now) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(rcpc_pkg::FRAC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q  <= sat_now;
      quot_q <= sat_now ? rcpc_pkg::FRAC_MAX : '0;
      r_q    <= {num_i, 16'd0};
      dsh_q  <= {den_i, 23'd0};
    end else if (busy_q) begin
      if (ge) begin
        r_q <= diff[RW-1:0];
      end
      quot_q <= {quot_q[rcpc_pkg::FRAC_W-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.rest = r_q != '0;
  assign res_o.quot = quot_q;

endmodule

FILE: rtl/ray_convex_polygon_clip.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | mode, edge_index, points, fraction, pose
// out     | output    | out_valid_o/out_ready_i | hit, hit_fraction, hit_normal_x/y
// cfg     | input     | cfg_valid_i/cfg_ready_o | edge_count (cfg_data_i)
// A query transforms the points, works through the edges in turn, runs a
// division for each edge that clips (cut short when the quotient saturates)
// and rotates the hit's normal; one shared 16x38 multiplier and a bit-serial divider
// set its length. One item at a time: in_ready_o is high only in idle, and a
// finished result waits in the output register while the next item is taken.
// Reset sets edge_count to 4; table contents are undefined until loaded.
module ray_convex_polygon_clip #(
  parameter int unsigned MAX_EDGES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [2:0]         edge_index_i,
  input  logic signed [31:0] point_a_x_i,
  input  logic signed [31:0] point_a_y_i,
  input  logic signed [31:0] point_b_x_i,
  input  logic signed [31:0] point_b_y_i,
  input  logic [23:0]        max_fraction_i,
  input  logic signed [31:0] body_pos_x_i,
  input  logic signed [31:0] body_pos_y_i,
  input  logic signed [15:0] rot_cos_i,
  input  logic signed [15:0] rot_sin_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [23:0]        hit_fraction_o,
  output logic signed [15:0] hit_normal_x_o,
  output logic signed [15:0] hit_normal_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned AccW = rcpc_pkg::NUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XF   = 4'd1;
  localparam logic [3:0] S_PRE  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_VD   = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_DEN  = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_NRM  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [2:0]    k_q;
  logic [CW-1:0] i_q, cnt_q;
  logic [3:0]    edge_count_q;
  logic          hitf_q;

  logic signed [32:0] dxa_q, dya_q, dxb_q, dyb_q;
  logic signed [15:0] c_q, s_q, nx_q, ny_q, hnx_q, hny_q, wnx_q, wny_q;
  logic signed [36:0] p1x_q, p1y_q, p2x_q, p2y_q;
  logic signed [37:0] ddx_q, ddy_q, vdx_q, vdy_q;
  logic signed [AccW-1:0] acc_q, num_q, den_q;
  logic [23:0]   lower_q, upper_q;
  logic          enter_q;

  logic          out_valid_q, out_hit_q;
  logic [23:0]   out_frac_q;
  logic signed [15:0] out_nx_q, out_ny_q;

  // shared multiplier
  logic signed [15:0]     ma;
  logic signed [37:0]     mb;
  logic signed [53:0]     prod;
  logic                   msub;
  logic signed [AccW-1:0] sum, rnd;
  logic signed [15:0]     rsat;

  logic          accept, load_we, next_last;
  logic [63:0]   vrd;
  logic [31:0]   nrd;
  logic [AW-1:0] waddr;
  logic [CW-1:0] cnt_new;

  logic                  div_start;
  logic [AccW-1:0]       div_n, div_d;
  rcpc_pkg::div_res_t    div_res;
  logic                  take_lower, dmiss;
  logic [23:0]           new_lower, new_upper;

  assign in_ready_o  = state_q == S_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign load_we     = accept && !mode_i && (5'(edge_index_i) < 5'(MAX_EDGES));
  assign waddr       = AW'(edge_index_i);
  assign cnt_new     = ({1'b0, edge_count_q} > 5'(MAX_EDGES)) ? CW'(MAX_EDGES)
                                                               : CW'(edge_count_q);
  assign next_last   = (i_q + CW'(1)) == cnt_q;

  rcpc_ram #(.Width(64), .Depth(MAX_EDGES)) u_vtx (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (waddr),
    .wdata_i ({point_a_y_i, point_a_x_i}),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (vrd)
  );

  rcpc_ram #(.Width(32), .Depth(MAX_EDGES)) u_nrm (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (waddr),
    .wdata_i ({point_b_y_i[15:0], point_b_x_i[15:0]}),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (nrd)
  );

  always_comb begin
    ma   = '0;
    mb   = '0;
    msub = 1'b0;
    unique case (state_q)
      S_XF: begin
        unique case (k_q)
          3'd0: begin ma = c_q; mb = 38'(dxa_q); end
          3'd1: begin ma = s_q; mb = 38'(dya_q); end
          3'd2: begin ma = c_q; mb = 38'(dya_q); end
          3'd3: begin ma = s_q; mb = 38'(dxa_q); msub = 1'b1; end
          3'd4: begin ma = c_q; mb = 38'(dxb_q); end
          3'd5: begin ma = s_q; mb = 38'(dyb_q); end
          3'd6: begin ma = c_q; mb = 38'(dyb_q); end
          default: begin ma = s_q; mb = 38'(dxb_q); msub = 1'b1; end
        endcase
      end
      S_NUM: begin
        ma = k_q[0] ? ny_q : nx_q;
        mb = k_q[0] ? vdy_q : vdx_q;
      end
      S_DEN: begin
        ma = k_q[0] ? ny_q : nx_q;
        mb = k_q[0] ? ddy_q : ddx_q;
      end
      S_NRM: begin
        unique case (k_q[1:0])
          2'd0: begin ma = c_q; mb = 38'(hnx_q); end
          2'd1: begin ma = s_q; mb = 38'(hny_q); msub = 1'b1; end
          2'd2: begin ma = s_q; mb = 38'(hnx_q); end
          default: begin ma = c_q; mb = 38'(hny_q); end
        endcase
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign sum  = !k_q[0] ? AccW'(prod) : (msub ? acc_q - AccW'(prod) : acc_q + AccW'(prod));
  assign rnd  = (sum + AccW'(8192)) >>> 14;
  assign rsat = (rnd > AccW'(32767)) ? 16'sh7fff :
                (rnd < -AccW'(32768)) ? 16'sh8000 : rnd[15:0];

  // edge decision: start a division where the edge clips
  always_comb begin
    div_start = 1'b0;
    div_n     = num_q;
    div_d     = den_q;
    if (state_q == S_DEC && den_q != '0) begin
      if (den_q[AccW-1] && num_q[AccW-1]) begin
        div_start = 1'b1;
        div_n     = -num_q;
        div_d     = -den_q;
      end else if (!den_q[AccW-1] && !num_q[AccW-1]) begin
        div_start = 1'b1;
      end
    end
  end

  rcpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .res_o   (div_res)
  );

  assign take_lower = enter_q && (div_res.sat || div_res.quot > lower_q ||
                      (div_res.quot == lower_q && div_res.rest));
  assign new_lower  = take_lower ? div_res.quot : lower_q;
  assign new_upper  = (!enter_q && !div_res.sat && div_res.quot < upper_q) ? div_res.quot
                                                                          : upper_q;
  assign dmiss      = new_upper < new_lower;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = mode_i ? S_XF : S_OUT;
      S_XF:   if (k_q == 3'd7) state_d = S_PRE;
      S_PRE:  state_d = (cnt_q == '0) ? S_OUT : S_RD;
      S_RD:   state_d = S_VD;
      S_VD:   state_d = S_NUM;
      S_NUM:  if (k_q[0]) state_d = S_DEN;
      S_DEN:  if (k_q[0]) state_d = S_DEC;
      S_DEC: begin
        if (div_start) begin
          state_d = S_DIV;
        end else if (den_q == '0 ? num_q[AccW-1] : (!den_q[AccW-1] && num_q[AccW-1])) begin
          state_d = S_OUT;
        end else begin
          state_d = next_last ? (hitf_q ? S_NRM : S_OUT) : S_RD;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (dmiss) begin
            state_d = S_OUT;
          end else if (next_last) begin
            state_d = (hitf_q || take_lower) ? S_NRM : S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_NRM:  if (k_q == 3'd3) state_d = S_OUT;
      S_OUT:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      i_q          <= '0;
      cnt_q        <= '0;
      edge_count_q <= 4'd4;
      hitf_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        edge_count_q <= cfg_data_i;
      end
      if (state_d != state_q) begin
        k_q <= '0;
      end else begin
        k_q <= k_q + 3'd1;
      end
      if (accept) begin
        hitf_q <= 1'b0;
        cnt_q  <= cnt_new;
      end
      if (state_q == S_PRE) begin
        i_q <= '0;
      end
      // advance to the next edge
      if ((state_q == S_DEC || state_q == S_DIV) && state_d == S_RD) begin
        i_q <= i_q + CW'(1);
      end
      if (state_q == S_DIV && div_res.done && take_lower && !dmiss) begin
        hitf_q <= 1'b1;
      end
      // drop the hit on any miss
      if ((state_q == S_DEC || state_q == S_DIV) && state_d == S_OUT &&
          !(state_q == S_DEC && !div_start && next_last &&
            !(den_q == '0 ? num_q[AccW-1] : (!den_q[AccW-1] && num_q[AccW-1])))) begin
        hitf_q <= 1'b0;
      end
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dxa_q   <= 33'(point_a_x_i) - 33'(body_pos_x_i);
      dya_q   <= 33'(point_a_y_i) - 33'(body_pos_y_i);
      dxb_q   <= 33'(point_b_x_i) - 33'(body_pos_x_i);
      dyb_q   <= 33'(point_b_y_i) - 33'(body_pos_y_i);
      c_q     <= rot_cos_i;
      s_q     <= rot_sin_i;
      upper_q <= max_fraction_i;
      lower_q <= '0;
    end
    if (state_q == S_XF || state_q == S_NUM || state_q == S_DEN || state_q == S_NRM) begin
      acc_q <= sum;
    end
    if (state_q == S_XF) begin
      unique case (k_q)
        3'd1: p1x_q <= rnd[36:0];
        3'd3: p1y_q <= rnd[36:0];
        3'd5: p2x_q <= rnd[36:0];
        3'd7: p2y_q <= rnd[36:0];
        default: ;
      endcase
    end
    if (state_q == S_PRE) begin
      ddx_q <= 38'(p2x_q) - 38'(p1x_q);
      ddy_q <= 38'(p2y_q) - 38'(p1y_q);
    end
    if (state_q == S_VD) begin
      vdx_q <= 38'($signed(vrd[31:0])) - 38'(p1x_q);
      vdy_q <= 38'($signed(vrd[63:32])) - 38'(p1y_q);
      nx_q  <= nrd[15:0];
      ny_q  <= nrd[31:16];
    end
    if (state_q == S_NUM && k_q[0]) begin
      num_q <= sum;
    end
    if (state_q == S_DEN && k_q[0]) begin
      den_q <= sum;
    end
    if (div_start) begin
      enter_q <= den_q[AccW-1];
    end
    if (state_q == S_DIV && div_res.done) begin
      lower_q <= new_lower;
      upper_q <= new_upper;
      if (take_lower) begin
        hnx_q <= nx_q;
        hny_q <= ny_q;
      end
    end
    if (state_q == S_NRM) begin
      if (k_q[1:0] == 2'd1) wnx_q <= rsat;
      if (k_q[1:0] == 2'd3) wny_q <= rsat;
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_hit_q  <= hitf_q;
      out_frac_q <= hitf_q ? lower_q : '0;
      out_nx_q   <= hitf_q ? wnx_q : '0;
      out_ny_q   <= hitf_q ? wny_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign hit_fraction_o = out_frac_q;
  assign hit_normal_x_o = out_nx_q;
  assign hit_normal_y_o = out_ny_q;

endmodule
